### rtl/core/fsrs_pkg.sv
// Package for the flash sector refresh scheduler.
// Holds field widths, fixed codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package fsrs_pkg;

    localparam int PAGE_W  = 12;
    localparam int CNT_W   = 16;
    localparam int LIM_W   = 14;
    localparam int CALC_W  = 18;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 14'd10000;
    localparam logic [CNT_W-1:0] UNWRITTEN   = 16'hFFFF;

    localparam logic FUNC_SCAN  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MAP1   = 8'b0000_0010,
        ST_MAP2   = 8'b0000_0100,
        ST_MAP3   = 8'b0000_1000,
        ST_READ   = 8'b0001_0000,
        ST_UPDATE = 8'b0010_0000,
        ST_WINDOW = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } t_state;

endpackage

### rtl/core/fsrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the per-sector counter table. No dependencies.
`timescale 1ns / 1ps

module fsrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fsrs_secmap.sv
// Three-stage page to sector mapping: page / PAGES_IN_SECTOR modulo SECTOR_COUNT.
// Both divisions use reciprocal multiplication. Depends on fsrs_pkg.
`timescale 1ns / 1ps

module fsrs_secmap #(
    parameter int SECTOR_COUNT    = 16,
    parameter int PAGES_IN_SECTOR = 256,
    localparam int SW = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1
) (
    input  logic                        i_clk,
    input  logic [fsrs_pkg::PAGE_W-1:0] i_page,
    output logic [SW-1:0]               o_sector
);

    localparam int PGW = fsrs_pkg::PAGE_W;
    localparam int S1  = PGW + 8;
    localparam int S2  = PGW + 6;
    localparam int M1W = S1 + 1;
    localparam int M2W = S2 + 1;
    localparam logic [M1W-1:0] RECIP1 =
        M1W'((2 ** S1 + PAGES_IN_SECTOR - 1) / PAGES_IN_SECTOR);
    localparam logic [M2W-1:0] RECIP2 =
        M2W'((2 ** S2 + SECTOR_COUNT - 1) / SECTOR_COUNT);
    localparam logic [PGW-1:0] SC_V = PGW'(SECTOR_COUNT);

    logic [PGW+M1W-1:0] r_prod1;
    logic [PGW+M2W-1:0] r_prod2;
    logic [PGW-1:0]     r_quot;
    logic [SW-1:0]      r_sector;
    logic [PGW-1:0]     n_quot;
    logic [PGW+M2W-1:0] n_prod2;
    logic [PGW-1:0]     n_quot2;
    logic [2*PGW-1:0]   n_back;
    logic [PGW-1:0]     n_rem;

    always_comb begin
        n_quot  = r_prod1[S1 +: PGW];
        n_prod2 = {{M2W{1'b0}}, n_quot} * {{PGW{1'b0}}, RECIP2};
        n_quot2 = r_prod2[S2 +: PGW];
        n_back  = {{PGW{1'b0}}, n_quot2} * {{PGW{1'b0}}, SC_V};
        n_rem   = r_quot - n_back[PGW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod1  <= {{M1W{1'b0}}, i_page} * {{PGW{1'b0}}, RECIP1};
        r_prod2  <= n_prod2;
        r_quot   <= n_quot;
        r_sector <= n_rem[SW-1:0];
    end

    assign o_sector = r_sector;

endmodule

### rtl/core/flash_sector_refresh_scheduler.sv
// Flash sector refresh scheduler: per-sector write counters in a RAM, scan and write sequencer.
// A scan word passes MAP1-MAP3, READ and UPDATE; a write word goes on through WINDOW and FINISH.
// Throughput: one word at a time; busy covers the three-stage sector mapping, the RAM read
// and the update steps, so the next word is taken only once the sequencer is back in idle.
// Reset is synchronous and active low; it clears the counters through per-sector valid bits
// and the scan maxima and loads the default limit. Results show for one cycle with o_done.
`timescale 1ns / 1ps

module flash_sector_refresh_scheduler #(
    parameter int SECTOR_COUNT    = 16,
    parameter int PAGES_IN_SECTOR = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fsrs_pkg::LIM_W-1:0]  i_cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [fsrs_pkg::PAGE_W-1:0] i_page,
    input  logic [fsrs_pkg::CNT_W-1:0]  i_stored_count,
    input  logic                        i_last_in_sector,
    output logic                        o_done,
    output logic [fsrs_pkg::CNT_W-1:0]  o_sector_count,
    output logic                        o_refresh_needed,
    output logic [fsrs_pkg::PAGE_W-1:0] o_refresh_page,
    output logic [fsrs_pkg::CNT_W-1:0]  o_refresh_count
);

    localparam int SW  = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int OW  = $clog2(PAGES_IN_SECTOR);
    localparam int PW  = $clog2(PAGES_IN_SECTOR + 1);
    localparam int PGW = fsrs_pkg::PAGE_W;
    localparam int CW  = fsrs_pkg::CNT_W;
    localparam int LW  = fsrs_pkg::LIM_W;
    localparam int XW  = fsrs_pkg::CALC_W;
    localparam int BW  = SW + PW + PGW;
    localparam logic [PW-1:0] PIS_V = PW'(PAGES_IN_SECTOR);
    localparam logic signed [XW-1:0] SPAN = XW'(2 * PAGES_IN_SECTOR - 1);

    fsrs_pkg::t_state r_state, n_state;

    logic [LW-1:0]   r_limit;
    logic            r_func;
    logic [PGW-1:0]  r_page;
    logic [CW-1:0]   r_stored;
    logic            r_last;
    logic [CW-1:0]   r_max_all, n_max_all;
    logic [CW-1:0]   r_max_below, n_max_below;
    logic [SECTOR_COUNT-1:0] r_valid;
    logic [PGW-1:0]  r_base;
    logic [CW-1:0]   r_w;
    logic            r_hit;
    logic signed [XW-1:0] r_off_raw;

    logic            r_done;
    logic [CW-1:0]   r_out_count;
    logic            r_out_needed;
    logic [PGW-1:0]  r_out_page;
    logic [CW-1:0]   r_out_rcount;

    logic [SW-1:0]   sector;
    logic [CW-1:0]   ram_rdata;
    logic            ram_we;
    logic [CW-1:0]   ram_wdata;

    logic [BW-1:0]   base_full;
    logic [CW-1:0]   rd_cnt;
    logic [CW-1:0]   upd_below;
    logic [CW-1:0]   upd_all;
    logic [CW-1:0]   chosen;
    logic [CW:0]     w_raw;
    logic [CW-1:0]   n_w;
    logic signed [XW-1:0] s_w, s_lim, s_lim2, s_lo1, s_rp;
    logic            win1, win2;
    logic [OW-1:0]   off;
    logic [PGW-1:0]  target;
    logic [CW-1:0]   w_final;

    fsrs_secmap #(
        .SECTOR_COUNT    (SECTOR_COUNT),
        .PAGES_IN_SECTOR (PAGES_IN_SECTOR)
    ) u_secmap (
        .i_clk    (i_clk),
        .i_page   (r_page),
        .o_sector (sector)
    );

    fsrs_ram #(
        .WIDTH (CW),
        .DEPTH (SECTOR_COUNT)
    ) u_counters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (sector),
        .i_wdata (ram_wdata),
        .i_raddr (sector),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        base_full = {{(SW + PGW){1'b0}}, PIS_V} * {{(PW + PGW){1'b0}}, sector};
        rd_cnt    = r_valid[sector] ? ram_rdata : '0;

        upd_below = r_max_below;
        upd_all   = r_max_all;
        if (r_stored != fsrs_pkg::UNWRITTEN) begin
            if ((r_stored <= {{(CW - LW){1'b0}}, r_limit}) && (r_stored > r_max_below)) begin
                upd_below = r_stored;
            end
            if (r_stored > r_max_all) begin
                upd_all = r_stored;
            end
        end
        chosen = (upd_below != '0) ? upd_below : upd_all;

        w_raw = {1'b0, rd_cnt} + (CW + 1)'(1);
        if (w_raw >= {{(CW - LW){1'b0}}, r_limit, 1'b0}) begin
            n_w = CW'(1);
        end else begin
            n_w = w_raw[CW-1:0];
        end

        s_w    = {{(XW - CW){1'b0}}, r_w};
        s_lim  = {{(XW - LW){1'b0}}, r_limit};
        s_lim2 = s_lim <<< 1;
        s_lo1  = s_lim - SPAN;
        win1   = (s_w >= s_lo1) && (s_w <= s_lim);
        win2   = (s_w >= (s_lim2 - SPAN)) && (s_w <= s_lim2);
        s_rp   = (s_w > s_lim) ? (s_w - s_lim) : s_w;

        off     = r_off_raw[XW-1] ? '0 : r_off_raw[OW:1];
        target  = r_base + {{(PGW - OW){1'b0}}, off};
        w_final = r_hit ? (r_w + CW'(1)) : r_w;

        ram_we    = 1'b0;
        ram_wdata = w_final;
        if ((r_state == fsrs_pkg::ST_UPDATE) && (r_func == fsrs_pkg::FUNC_SCAN) && r_last) begin
            ram_we    = 1'b1;
            ram_wdata = chosen;
        end else if (r_state == fsrs_pkg::ST_FINISH) begin
            ram_we    = 1'b1;
        end

        n_max_all   = r_max_all;
        n_max_below = r_max_below;
        if ((r_state == fsrs_pkg::ST_UPDATE) && (r_func == fsrs_pkg::FUNC_SCAN)) begin
            n_max_all   = r_last ? '0 : upd_all;
            n_max_below = r_last ? '0 : upd_below;
        end

        case (r_state)
            fsrs_pkg::ST_IDLE: begin
                n_state = start ? fsrs_pkg::ST_MAP1 : fsrs_pkg::ST_IDLE;
            end
            fsrs_pkg::ST_MAP1: begin
                n_state = fsrs_pkg::ST_MAP2;
            end
            fsrs_pkg::ST_MAP2: begin
                n_state = fsrs_pkg::ST_MAP3;
            end
            fsrs_pkg::ST_MAP3: begin
                n_state = fsrs_pkg::ST_READ;
            end
            fsrs_pkg::ST_READ: begin
                n_state = fsrs_pkg::ST_UPDATE;
            end
            fsrs_pkg::ST_UPDATE: begin
                n_state = (r_func == fsrs_pkg::FUNC_WRITE) ? fsrs_pkg::ST_WINDOW
                                                           : fsrs_pkg::ST_IDLE;
            end
            fsrs_pkg::ST_WINDOW: begin
                n_state = fsrs_pkg::ST_FINISH;
            end
            fsrs_pkg::ST_FINISH: begin
                n_state = fsrs_pkg::ST_IDLE;
            end
            default: begin
                n_state = fsrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsrs_pkg::ST_IDLE;
            r_limit     <= fsrs_pkg::LIMIT_RESET;
            r_max_all   <= '0;
            r_max_below <= '0;
            r_valid     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_max_all   <= n_max_all;
            r_max_below <= n_max_below;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[sector] <= 1'b1;
            end
            r_done <= ((r_state == fsrs_pkg::ST_UPDATE) && (r_func == fsrs_pkg::FUNC_SCAN))
                      || (r_state == fsrs_pkg::ST_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == fsrs_pkg::ST_IDLE) && start) begin
            r_func   <= i_func;
            r_page   <= i_page;
            r_stored <= i_stored_count;
            r_last   <= i_last_in_sector;
        end
        if (r_state == fsrs_pkg::ST_READ) begin
            r_base <= base_full[PGW-1:0];
        end
        if (r_state == fsrs_pkg::ST_UPDATE) begin
            r_w <= n_w;
        end
        if (r_state == fsrs_pkg::ST_WINDOW) begin
            r_hit     <= win1 || win2;
            r_off_raw <= s_rp - s_lo1;
        end
        if ((r_state == fsrs_pkg::ST_UPDATE) && (r_func == fsrs_pkg::FUNC_SCAN)) begin
            r_out_count  <= chosen;
            r_out_needed <= 1'b0;
            r_out_page   <= '0;
            r_out_rcount <= '0;
        end else if (r_state == fsrs_pkg::ST_FINISH) begin
            r_out_count  <= r_w;
            r_out_needed <= r_hit;
            r_out_page   <= r_hit ? target : '0;
            r_out_rcount <= r_hit ? w_final : '0;
        end
    end

    assign busy             = (r_state != fsrs_pkg::ST_IDLE);
    assign o_done           = r_done;
    assign o_sector_count   = r_out_count;
    assign o_refresh_needed = r_out_needed;
    assign o_refresh_page   = r_out_page;
    assign o_refresh_count  = r_out_rcount;

endmodule
